// ----- rtl/counting_pb_propagate_assert.svh -----
// Assertion macros for the counting propagator.
`ifndef COUNTING_PB_PROPAGATE_ASSERT_SVH
`define COUNTING_PB_PROPAGATE_ASSERT_SVH
// An implication that is checked on every rising edge outside reset.
`define CPB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// A signal that must hold on the edge after a condition.
`define CPB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- rtl/cpb_pkg.sv -----
// Package with the types and constants of the counting propagator.
package cpb_pkg;
	localparam int MaxTerms = 32;
	localparam int CoefW = 31;
	localparam int LitW = 32;
	localparam int SlackW = 38;
	localparam int DegW = 37;
	localparam int CntW = 6;
	localparam logic signed [SlackW-1:0] SlackMax = {1'b0, {(SlackW-1){1'b1}}};
	localparam logic signed [SlackW-1:0] SlackMin = {1'b1, {(SlackW-1){1'b0}}};

	typedef enum logic [2:0] {
		OP_LOAD = 3'd0, OP_START = 3'd1, OP_FALSIFY = 3'd2,
		OP_ASSIGN = 3'd3, OP_UNASSIGN = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		KIND_DONE = 2'd0, KIND_IMPLIED = 2'd1, KIND_CONFLICT = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_UNKNOWN = 2'd0, ST_TRUE = 2'd1, ST_FALSE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE, S_SUM, S_UPD, S_CHECK, S_SCAN, S_OUT
	} state_t;

	// Commands broadcast from the sequencer to the row of cells.
	typedef struct packed {
		logic load;
		logic set_status;
		status_t new_status;
		logic shift;
	} cell_ctl_t;

	function automatic logic signed [SlackW-1:0] sat(input logic signed [SlackW+1:0] v);
		if (v > $signed({{2{SlackMax[SlackW-1]}}, SlackMax})) return SlackMax;
		if (v < $signed({{2{SlackMin[SlackW-1]}}, SlackMin})) return SlackMin;
		return v[SlackW-1:0];
	endfunction
endpackage

// ----- rtl/cpb_cell.sv -----
// One term cell: holds a term and passes it along a rotating ring.
module cpb_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cpb_pkg::cell_ctl_t            ctl,
	input  logic                          sel,
	input  logic [cpb_pkg::CoefW-1:0]     coef_in,
	input  logic [cpb_pkg::LitW-1:0]      lit_in,
	input  logic [cpb_pkg::CoefW-1:0]     ring_coef_in,
	input  logic [cpb_pkg::LitW-1:0]      ring_lit_in,
	input  cpb_pkg::status_t              ring_st_in,
	output logic [cpb_pkg::CoefW-1:0]     coef_q,
	output logic [cpb_pkg::LitW-1:0]      lit_q,
	output cpb_pkg::status_t              st_q
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= cpb_pkg::ST_UNKNOWN;
		end else if (ctl.shift) begin
			st_q <= ring_st_in;
		end else if (sel && ctl.load) begin
			st_q <= cpb_pkg::ST_UNKNOWN;
		end else if (sel && ctl.set_status) begin
			st_q <= ctl.new_status;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			coef_q <= ring_coef_in;
			lit_q  <= ring_lit_in;
		end else if (sel && ctl.load) begin
			coef_q <= coef_in;
			lit_q  <= lit_in;
		end
	end
endmodule

// ----- rtl/counting_pb_propagate.sv -----
// Top level of the counting propagator for one pseudo-Boolean constraint.
//
// Usage: words enter on the operation channel (valid/ready); results leave
// on the result channel (valid/ready), the final word of each input marked
// by last. degree and term_count are written through cfg_we/cfg_index/
// cfg_data while the block is idle.
// Terms live in a ring of MAX_TERMS cells that rotates one place per cycle
// while it shifts, so the head cell always presents term 0, 1, 2 ... in
// turn; a full turn restores the original order.
// Load, assign and unassign rotate to the term, act on it and rotate back
// home before the done word. Start sums over one full turn, then scans;
// falsify rotates to the term, updates slack and scans. A scan steps
// through the terms until it stops, and the ring is then rotated back to
// its home position; one item is handled at a time.
// Reset clears slack and marks every term unknown; registers take their
// reset values. Whilst the receiver stalls, the pending result word holds
// and the scan and the final word wait for it, lengthening the step.
module counting_pb_propagate #(
	parameter int MAX_TERMS = cpb_pkg::MaxTerms
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [cpb_pkg::DegW-1:0]          cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [2:0]                        operation,
	input  logic [4:0]                        term_index,
	input  logic [cpb_pkg::CoefW-1:0]         coefficient,
	input  logic signed [cpb_pkg::LitW-1:0]   literal,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        kind,
	output logic [4:0]                        term_index_res,
	output logic signed [cpb_pkg::LitW-1:0]   literal_res,
	output logic signed [cpb_pkg::SlackW-1:0] slack_value,
	output logic                              last
);
	localparam int IdxW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int PosW = $clog2(MAX_TERMS + 1);
	// Marks a step whose scan has finished and only needs its done word.
	localparam logic [2:0] OpScanDone = 3'd7;

	logic [cpb_pkg::DegW-1:0] degree_q;
	logic [cpb_pkg::CntW-1:0] term_count_q;
	logic signed [cpb_pkg::SlackW-1:0] slack_q;
	cpb_pkg::state_t state_q, state_d;
	logic [2:0] op_q;
	logic [4:0] idx_q;
	logic [cpb_pkg::CoefW-1:0] coef_in_q;
	logic [cpb_pkg::LitW-1:0] lit_in_q;
	logic [PosW-1:0] pos_q, pos_d;
	logic signed [cpb_pkg::SlackW+1:0] sum_q, sum_d;
	logic [1:0] kind_q;
	logic [4:0] ridx_q;
	logic [cpb_pkg::LitW-1:0] rlit_q;
	logic signed [cpb_pkg::SlackW-1:0] rslack_q;
	logic last_q, ov_q;
	logic [PosW-1:0] active;
	logic in_use;
	cpb_pkg::cell_ctl_t ctl;
	cpb_pkg::status_t head_st_out;

	logic [cpb_pkg::CoefW-1:0] c_coef [MAX_TERMS];
	logic [cpb_pkg::LitW-1:0]  c_lit  [MAX_TERMS];
	cpb_pkg::status_t          c_st   [MAX_TERMS];

	assign active = (term_count_q > cpb_pkg::CntW'(MAX_TERMS)) ? PosW'(MAX_TERMS)
		: PosW'(term_count_q);
	assign in_use = ({1'b0, idx_q} < (PosW+1)'(MAX_TERMS)) &&
		({1'b0, idx_q} < (PosW+1)'(active));

	// A status written to the head while the ring moves travels on to the tail.
	assign head_st_out = ctl.set_status ? ctl.new_status : c_st[0];

	// Ring of cells; cell 0 is the head, fed from cell 1, and the last cell is fed back from the head.
	for (genvar g = 0; g < MAX_TERMS; g++) begin : g_cell
		localparam int Prev = (g + 1) % MAX_TERMS;
		cpb_cell u_cell (
			.clk, .arst_n, .ctl,
			.sel(g == 0),
			.coef_in(coef_in_q), .lit_in(lit_in_q),
			.ring_coef_in(c_coef[Prev]), .ring_lit_in(c_lit[Prev]),
			.ring_st_in((g == MAX_TERMS - 1) ? head_st_out : c_st[Prev]),
			.coef_q(c_coef[g]), .lit_q(c_lit[g]), .st_q(c_st[g])
		);
	end

	logic signed [cpb_pkg::SlackW+1:0] head_coef, upd;
	assign head_coef = (cpb_pkg::SlackW+2)'(c_coef[0]);
	always_comb begin
		if (op_q == cpb_pkg::OP_FALSIFY) upd = slack_q - head_coef;
		else upd = slack_q + head_coef;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
			term_count_q <= cpb_pkg::CntW'(1);
		end else if (cfg_we) begin
			if (cfg_index) term_count_q <= cfg_data[cpb_pkg::CntW-1:0];
			else degree_q <= cfg_data;
		end
	end

	logic in_acc, out_acc;
	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign in_ready = (state_q == cpb_pkg::S_IDLE);
	assign out_valid = ov_q;
	assign kind = kind_q;
	assign term_index_res = ridx_q;
	assign literal_res = rlit_q;
	assign slack_value = rslack_q;
	assign last = last_q;

	logic emit, emit_last, set_slack;
	logic [1:0] ek;
	logic signed [cpb_pkg::SlackW-1:0] new_slack;
	logic [PosW-1:0] scan_lim;
	assign scan_lim = active;

	always_comb begin
		state_d = state_q;
		pos_d = pos_q;
		sum_d = sum_q;
		ctl = '0;
		ctl.new_status = cpb_pkg::ST_UNKNOWN;
		emit = 1'b0;
		emit_last = 1'b0;
		ek = cpb_pkg::KIND_DONE;
		set_slack = 1'b0;
		new_slack = slack_q;
		unique case (state_q)
			cpb_pkg::S_IDLE: begin
				if (in_acc) begin
					pos_d = '0;
					sum_d = -(cpb_pkg::SlackW+2)'(degree_q);
					unique case (operation)
						cpb_pkg::OP_START: state_d = cpb_pkg::S_SUM;
						cpb_pkg::OP_FALSIFY, cpb_pkg::OP_ASSIGN, cpb_pkg::OP_UNASSIGN:
							state_d = cpb_pkg::S_UPD;
						cpb_pkg::OP_LOAD: state_d = cpb_pkg::S_UPD;
						default: state_d = cpb_pkg::S_OUT;
					endcase
				end
			end
			cpb_pkg::S_SUM: begin
				// One full turn; terms past the count and false terms do not add.
				if (pos_q < active && c_st[0] != cpb_pkg::ST_FALSE)
					sum_d = sum_q + head_coef;
				ctl.shift = 1'b1;
				if (pos_q == PosW'(MAX_TERMS - 1)) begin
					pos_d = '0;
					set_slack = 1'b1;
					new_slack = cpb_pkg::sat(sum_d);
					state_d = cpb_pkg::S_CHECK;
				end else begin
					pos_d = pos_q + 1'b1;
				end
			end
			cpb_pkg::S_UPD: begin
				// Rotate until the addressed term sits in the head cell.
				if (op_q == cpb_pkg::OP_LOAD && {1'b0, idx_q} >= (PosW+1)'(MAX_TERMS)) begin
					state_d = cpb_pkg::S_OUT;
				end else if (op_q != cpb_pkg::OP_LOAD && !in_use) begin
					state_d = cpb_pkg::S_OUT;
				end else if (pos_q != PosW'(idx_q)) begin
					ctl.shift = 1'b1;
					pos_d = pos_q + 1'b1;
				end else begin
					unique case (op_q)
						cpb_pkg::OP_LOAD: begin
							ctl.load = 1'b1;
							state_d = cpb_pkg::S_OUT;
						end
						cpb_pkg::OP_FALSIFY: begin
							if (c_st[0] != cpb_pkg::ST_FALSE) begin
								set_slack = 1'b1;
								new_slack = cpb_pkg::sat(upd);
							end
							ctl.set_status = 1'b1;
							ctl.new_status = cpb_pkg::ST_FALSE;
							state_d = cpb_pkg::S_CHECK;
						end
						default: begin
							if (c_st[0] == cpb_pkg::ST_FALSE) begin
								set_slack = 1'b1;
								new_slack = cpb_pkg::sat(upd);
							end
							ctl.set_status = 1'b1;
							ctl.new_status = (op_q == cpb_pkg::OP_ASSIGN) ?
								cpb_pkg::ST_TRUE : cpb_pkg::ST_UNKNOWN;
							state_d = cpb_pkg::S_OUT;
						end
					endcase
				end
			end
			cpb_pkg::S_CHECK: begin
				// Rotate back home before scanning from term 0.
				if (pos_q != '0) begin
					ctl.shift = 1'b1;
					pos_d = (pos_q == PosW'(MAX_TERMS - 1)) ? '0 : pos_q + 1'b1;
				end else if (slack_q < 0) begin
					if (!ov_q || out_ready) begin
						emit = 1'b1; emit_last = 1'b1; ek = cpb_pkg::KIND_CONFLICT;
						state_d = cpb_pkg::S_IDLE;
					end
				end else begin
					state_d = cpb_pkg::S_SCAN;
				end
			end
			cpb_pkg::S_SCAN: begin
				if (!ov_q || out_ready) begin
					if (pos_q < scan_lim &&
						(cpb_pkg::SlackW+2)'(c_coef[0]) > (cpb_pkg::SlackW+2)'(slack_q)) begin
						if (c_st[0] == cpb_pkg::ST_UNKNOWN) begin
							emit = 1'b1; ek = cpb_pkg::KIND_IMPLIED;
							ctl.set_status = 1'b1;
							ctl.new_status = cpb_pkg::ST_TRUE;
						end
						ctl.shift = 1'b1;
						pos_d = pos_q + 1'b1;
					end else if (pos_q == PosW'(MAX_TERMS)) begin
						// A scan over every term has already come round to home.
						pos_d = '0;
						state_d = cpb_pkg::S_OUT;
					end else begin
						state_d = (pos_q == '0) ? cpb_pkg::S_OUT : cpb_pkg::S_CHECK;
					end
				end
			end
			cpb_pkg::S_OUT: begin
				if (pos_q != '0) begin
					ctl.shift = 1'b1;
					pos_d = (pos_q == PosW'(MAX_TERMS - 1)) ? '0 : pos_q + 1'b1;
				end else if (!ov_q || out_ready) begin
					emit = 1'b1; emit_last = 1'b1;
					state_d = cpb_pkg::S_IDLE;
				end
			end
			default: state_d = cpb_pkg::S_IDLE;
		endcase
		// CHECK after a finished scan must only emit the done word.
		if (state_q == cpb_pkg::S_CHECK && state_d == cpb_pkg::S_SCAN && op_q == OpScanDone)
			state_d = cpb_pkg::S_OUT;
	end

	// A scan that rewinds returns through S_CHECK; op_q is then tagged so
	// that the second visit ends in the done word instead of a rescan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpb_pkg::S_IDLE;
			pos_q <= '0;
			slack_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pos_q <= pos_d;
			if (set_slack) slack_q <= new_slack;
			if (emit) ov_q <= 1'b1;
			else if (out_acc) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		sum_q <= sum_d;
		if (in_acc) begin
			op_q <= operation;
			idx_q <= term_index;
			coef_in_q <= coefficient;
			lit_in_q <= literal;
		end else if (state_q == cpb_pkg::S_SCAN && state_d == cpb_pkg::S_CHECK) begin
			op_q <= OpScanDone;
		end
		if (emit) begin
			kind_q <= ek;
			last_q <= emit_last;
			ridx_q <= (ek == cpb_pkg::KIND_IMPLIED) ? 5'(pos_q[IdxW-1:0]) : '0;
			rlit_q <= (ek == cpb_pkg::KIND_IMPLIED) ? c_lit[0] : '0;
			rslack_q <= slack_q;
		end
	end

	`include "counting_pb_propagate_assert.svh"
	`CPB_ASSERT_IMP(a_hold, ov_q && !out_ready, !emit, "result overwritten")
	`CPB_ASSERT_IMP(a_conf_last, out_valid && kind == cpb_pkg::KIND_CONFLICT, last, "conflict not last")
	`CPB_ASSERT_NEXT(a_busy, in_acc, !in_ready, "accepted while busy")
endmodule
